/* src/gdo_pkg.sv */
// Shared types and calendar constants for the Gregorian date offset block.
// Used by gdo_mul, gregorian_date_offset and the bench gdo_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gdo_pkg;

	localparam int YEAR_W = 17;
	localparam int DNUM_W = 28;
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 17;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	localparam int Q100_SHIFT = 23;
	localparam int Q100_W = 10;
	localparam int YEST_SHIFT = 24;

	localparam logic [MUL_B_W-1:0] RECIP_100 = 17'd83887;
	localparam logic [MUL_B_W-1:0] RECIP_YEAR = 17'd45934;
	localparam logic [MUL_B_W-1:0] DAYS_YEAR = 17'd365;

	localparam int DEF_YEAR = 1900;
	localparam int DIFF_MAX = 4194303;
	localparam int DIFF_MIN = -4194304;

	typedef logic signed [DNUM_W-1:0] dnum_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	localparam logic [4:0] MONTH_LEN [0:15] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	localparam logic [8:0] CUM_DAYS [0:15] = '{
		9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
	};

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		month_days = MONTH_LEN[m] + 5'((m == 4'd2) && leap);
	endfunction

endpackage

`default_nettype wire

/* src/gregorian_date_offset.sv */
// Top level of the Gregorian date offset block: sequencer and accumulator.
// Depends on gdo_pkg and gdo_mul.
//
//   channel   handshake          payload
//   command   start / busy       mode, base_*, other_*, offset
//   result    done (strobe)      res_year, res_month, res_day, day_difference,
//                                base_replaced, out_of_range
//
// Each year number passes through the shared multiplier and adder in the states
// ST_J_Q, ST_J_M, ST_J_A1 and ST_J_A2, and in the year search one compare; the
// search takes two or three of those, the month walk up to eleven steps and a
// closing step, and a shift that saturates skips both.
// Reset clears the sequencer; no sweep follows it. done is high for one cycle
// and the receiver cannot stall it; start is taken again in that same cycle.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_offset #(
	parameter int YEAR_MAX = 9999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [13:0]        base_year,
	input  logic [3:0]         base_month,
	input  logic [4:0]         base_day,
	input  logic [13:0]        other_year,
	input  logic [3:0]         other_month,
	input  logic [4:0]         other_day,
	input  logic signed [22:0] offset,
	output logic               done,
	output logic [13:0]        res_year,
	output logic [3:0]         res_month,
	output logic [4:0]         res_day,
	output logic signed [22:0] day_difference,
	output logic               base_replaced,
	output logic               out_of_range
);

	localparam logic [gdo_pkg::YEAR_W-1:0] YearMaxC = gdo_pkg::YEAR_W'(YEAR_MAX);
	localparam logic [13:0] ResYearMax = 14'(YEAR_MAX);
	localparam gdo_pkg::dnum_t NMaxC = gdo_pkg::dnum_t'(365 * YEAR_MAX + YEAR_MAX / 4
		- YEAR_MAX / 100 + YEAR_MAX / 400 - 1);
	localparam gdo_pkg::dnum_t DiffMaxC = gdo_pkg::dnum_t'(gdo_pkg::DIFF_MAX);
	localparam gdo_pkg::dnum_t DiffMinC = gdo_pkg::dnum_t'(gdo_pkg::DIFF_MIN);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAP_MUL,
		ST_LEAP_CHK,
		ST_J_Q,
		ST_J_M,
		ST_J_A1,
		ST_J_A2,
		ST_DN_FIN,
		ST_DIFF,
		ST_SHIFT,
		ST_SAT,
		ST_EST,
		ST_SRCH_LO,
		ST_SRCH_HI,
		ST_MWALK
	} state_t;

	typedef enum logic [1:0] {
		RET_DN,
		RET_LO,
		RET_HI
	} ret_t;

	state_t                          state_q;
	ret_t                            ret_q;
	logic                            mode_q;
	logic                            other_q;
	logic signed [22:0]              off_q;
	logic [13:0]                     oy_q;
	logic [3:0]                      om_q;
	logic [4:0]                      od_q;
	logic [gdo_pkg::YEAR_W-1:0]      y_q;
	logic [3:0]                      m_q;
	logic [4:0]                      d_q;
	logic                            leap_q;
	logic [gdo_pkg::YEAR_W-1:0]      p_q;
	logic [gdo_pkg::Q100_W-1:0]      q_q;
	gdo_pkg::dnum_t                  acc_q;
	gdo_pkg::dnum_t                  nb_q;
	gdo_pkg::dnum_t                  n_q;
	gdo_pkg::dnum_t                  jlo_q;
	logic [8:0]                      rem_q;
	logic                            replaced_q;
	logic                            done_q;
	logic [13:0]                     res_year_q;
	logic [3:0]                      res_month_q;
	logic [4:0]                      res_day_q;
	logic signed [22:0]              diff_q;
	logic                            base_replaced_q;
	logic                            oor_q;

	gdo_pkg::mul_req_t               mul_req;
	logic [gdo_pkg::PROD_W-1:0]      prod;

	logic [gdo_pkg::Q100_W-1:0]      qy;
	logic [gdo_pkg::YEAR_W-1:0]      hund;
	logic                            leap_c;
	logic [4:0]                      mlen_chk;
	logic                            valid_c;
	gdo_pkg::dnum_t                  dn;
	gdo_pkg::dnum_t                  dv;
	gdo_pkg::dnum_t                  rv;
	gdo_pkg::dnum_t                  yl;
	logic [4:0]                      mlen_walk;

	gdo_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	always_comb begin
		mul_req = '0;
		unique case (state_q)
			ST_LEAP_MUL: begin
				mul_req.a = gdo_pkg::MUL_A_W'(y_q);
				mul_req.b = gdo_pkg::RECIP_100;
			end
			ST_J_Q: begin
				mul_req.a = gdo_pkg::MUL_A_W'(p_q);
				mul_req.b = gdo_pkg::RECIP_100;
			end
			ST_J_M: begin
				mul_req.a = gdo_pkg::MUL_A_W'(p_q);
				mul_req.b = gdo_pkg::DAYS_YEAR;
			end
			ST_SAT: begin
				mul_req.a = n_q[gdo_pkg::MUL_A_W-1:0];
				mul_req.b = gdo_pkg::RECIP_YEAR;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	assign qy = prod[gdo_pkg::Q100_SHIFT +: gdo_pkg::Q100_W];
	assign hund = gdo_pkg::YEAR_W'(gdo_pkg::YEAR_W'(qy) * gdo_pkg::YEAR_W'(100));
	assign leap_c = (y_q[1:0] == 2'd0) && ((hund != y_q) || (qy[1:0] == 2'd0));
	assign mlen_chk = gdo_pkg::month_days(m_q, leap_c);
	assign valid_c = (y_q != '0) && (y_q <= YearMaxC) && (m_q >= 4'd1) && (m_q <= 4'd12)
		&& (d_q != 5'd0) && (d_q <= mlen_chk);

	assign dn = acc_q + gdo_pkg::dnum_t'(gdo_pkg::CUM_DAYS[m_q])
		+ gdo_pkg::dnum_t'(leap_q && (m_q > 4'd2)) + gdo_pkg::dnum_t'(d_q)
		- gdo_pkg::dnum_t'(1);
	assign dv = nb_q - acc_q;
	assign rv = n_q - jlo_q;
	assign yl = acc_q - jlo_q;
	assign mlen_walk = gdo_pkg::month_days(m_q, leap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			ret_q           <= RET_DN;
			mode_q          <= 1'b0;
			other_q         <= 1'b0;
			off_q           <= '0;
			oy_q            <= '0;
			om_q            <= '0;
			od_q            <= '0;
			y_q             <= '0;
			m_q             <= '0;
			d_q             <= '0;
			leap_q          <= 1'b0;
			p_q             <= '0;
			q_q             <= '0;
			acc_q           <= '0;
			nb_q            <= '0;
			n_q             <= '0;
			jlo_q           <= '0;
			rem_q           <= '0;
			replaced_q      <= 1'b0;
			done_q          <= 1'b0;
			res_year_q      <= '0;
			res_month_q     <= '0;
			res_day_q       <= '0;
			diff_q          <= '0;
			base_replaced_q <= 1'b0;
			oor_q           <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q     <= mode;
						other_q    <= 1'b0;
						replaced_q <= 1'b0;
						off_q      <= offset;
						oy_q       <= other_year;
						om_q       <= other_month;
						od_q       <= other_day;
						y_q        <= gdo_pkg::YEAR_W'(base_year);
						m_q        <= base_month;
						d_q        <= base_day;
						state_q    <= ST_LEAP_MUL;
					end
				end
				ST_LEAP_MUL: begin
					state_q <= ST_LEAP_CHK;
				end
				ST_LEAP_CHK: begin
					ret_q <= RET_DN;
					if (valid_c) begin
						leap_q <= leap_c;
						p_q    <= y_q - gdo_pkg::YEAR_W'(1);
					end else begin
						y_q    <= gdo_pkg::YEAR_W'(gdo_pkg::DEF_YEAR);
						m_q    <= 4'd1;
						d_q    <= 5'd1;
						leap_q <= 1'b0;
						p_q    <= gdo_pkg::YEAR_W'(gdo_pkg::DEF_YEAR - 1);
						if (!other_q) begin
							replaced_q <= 1'b1;
						end
					end
					state_q <= ST_J_Q;
				end
				ST_J_Q: begin
					state_q <= ST_J_M;
				end
				ST_J_M: begin
					q_q     <= qy;
					state_q <= ST_J_A1;
				end
				ST_J_A1: begin
					acc_q   <= gdo_pkg::dnum_t'(prod[24:0]) + gdo_pkg::dnum_t'(p_q >> 2);
					state_q <= ST_J_A2;
				end
				ST_J_A2: begin
					acc_q <= acc_q - gdo_pkg::dnum_t'(q_q) + gdo_pkg::dnum_t'(q_q >> 2);
					unique case (ret_q)
						RET_DN:  state_q <= ST_DN_FIN;
						RET_LO:  state_q <= ST_SRCH_LO;
						RET_HI:  state_q <= ST_SRCH_HI;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DN_FIN: begin
					if (!other_q) begin
						nb_q <= dn;
						if (mode_q) begin
							other_q <= 1'b1;
							y_q     <= gdo_pkg::YEAR_W'(oy_q);
							m_q     <= om_q;
							d_q     <= od_q;
							state_q <= ST_LEAP_MUL;
						end else begin
							state_q <= ST_SHIFT;
						end
					end else begin
						acc_q   <= dn;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					if (dv > DiffMaxC) begin
						diff_q <= DiffMaxC[22:0];
					end else if (dv < DiffMinC) begin
						diff_q <= DiffMinC[22:0];
					end else begin
						diff_q <= dv[22:0];
					end
					res_year_q      <= '0;
					res_month_q     <= '0;
					res_day_q       <= '0;
					oor_q           <= 1'b0;
					base_replaced_q <= replaced_q;
					done_q          <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_SHIFT: begin
					n_q     <= nb_q + gdo_pkg::dnum_t'(off_q);
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (n_q < 0) begin
						res_year_q      <= 14'd1;
						res_month_q     <= 4'd1;
						res_day_q       <= 5'd1;
						diff_q          <= '0;
						oor_q           <= 1'b1;
						base_replaced_q <= replaced_q;
						done_q          <= 1'b1;
						state_q         <= ST_IDLE;
					end else if (n_q > NMaxC) begin
						res_year_q      <= ResYearMax;
						res_month_q     <= 4'd12;
						res_day_q       <= 5'd31;
						diff_q          <= '0;
						oor_q           <= 1'b1;
						base_replaced_q <= replaced_q;
						done_q          <= 1'b1;
						state_q         <= ST_IDLE;
					end else begin
						state_q <= ST_EST;
					end
				end
				ST_EST: begin
					p_q     <= prod[gdo_pkg::YEST_SHIFT +: gdo_pkg::YEAR_W];
					ret_q   <= RET_LO;
					state_q <= ST_J_Q;
				end
				ST_SRCH_LO: begin
					if (n_q < acc_q) begin
						p_q <= p_q - gdo_pkg::YEAR_W'(1);
					end else begin
						jlo_q <= acc_q;
						p_q   <= p_q + gdo_pkg::YEAR_W'(1);
						ret_q <= RET_HI;
					end
					state_q <= ST_J_Q;
				end
				ST_SRCH_HI: begin
					if (n_q >= acc_q) begin
						jlo_q   <= acc_q;
						p_q     <= p_q + gdo_pkg::YEAR_W'(1);
						state_q <= ST_J_Q;
					end else begin
						rem_q   <= rv[8:0];
						leap_q  <= (yl != gdo_pkg::dnum_t'(365));
						m_q     <= 4'd1;
						state_q <= ST_MWALK;
					end
				end
				ST_MWALK: begin
					if ((m_q < 4'd12) && (rem_q >= 9'(mlen_walk))) begin
						rem_q <= rem_q - 9'(mlen_walk);
						m_q   <= m_q + 4'd1;
					end else begin
						res_year_q      <= p_q[13:0];
						res_month_q     <= m_q;
						res_day_q       <= 5'(rem_q + 9'd1);
						diff_q          <= '0;
						oor_q           <= 1'b0;
						base_replaced_q <= replaced_q;
						done_q          <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign res_year       = res_year_q;
	assign res_month      = res_month_q;
	assign res_day        = res_day_q;
	assign day_difference = diff_q;
	assign base_replaced  = base_replaced_q;
	assign out_of_range   = oor_q;

endmodule

`default_nettype wire

/* src/gdo_mul.sv */
// Shared multiplier of the date offset block, product registered.
// Depends on gdo_pkg for the request type and widths.
`timescale 1ns / 1ps
`default_nettype none

module gdo_mul (
	input  logic                        clk,
	input  gdo_pkg::mul_req_t           req,
	output logic [gdo_pkg::PROD_W-1:0]  prod
);

	logic [gdo_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= gdo_pkg::PROD_W'(req.a) * gdo_pkg::PROD_W'(req.b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

/* src/gdo_checker.sv */
// Port-level checks of the Gregorian date offset block, bound to its top level.
// Depends on nothing but the ports of gregorian_date_offset.
`timescale 1ns / 1ps
`default_nettype none

module gdo_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [13:0]        res_year,
	input logic [3:0]         res_month,
	input logic [4:0]         res_day,
	input logic signed [22:0] day_difference
);

	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not raise busy");

	ap_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside end of work");

	ap_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	ap_mode_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((day_difference == 23'sd0)
			|| ((res_year == 14'd0) && (res_month == 4'd0) && (res_day == 5'd0))))
		else $error("date and difference both set in one result");

endmodule

bind gregorian_date_offset gdo_port_checks u_gdo_port_checks (.*);

`default_nettype wire

/* bench/gdo_tb_pkg.sv */
// Operation codes and the predicted result record for the date offset bench.
// Shared by gdo_checker and tb; depends on nothing.
`timescale 1ns / 1ps

package gdo_tb_pkg;

	typedef enum logic {
		MODE_SHIFT = 1'b0,
		MODE_DIFF  = 1'b1
	} date_op_e;

	typedef struct {
		logic [13:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic signed [22:0] diff;
		logic               replaced;
		logic               oor;
	} date_result_t;

endpackage

/* bench/gdo_checker.sv */
// Checker for gregorian_date_offset: predicts each result of an accepted command
// and compares it with what the block returns. Depends on gdo_pkg and gdo_tb_pkg.
`timescale 1ns / 1ps

module gdo_checker #(
	parameter int YEAR_MAX = 9999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               mode,
	input  logic [13:0]        base_year,
	input  logic [3:0]         base_month,
	input  logic [4:0]         base_day,
	input  logic [13:0]        other_year,
	input  logic [3:0]         other_month,
	input  logic [4:0]         other_day,
	input  logic signed [22:0] offset,
	input  logic               done,
	input  logic [13:0]        res_year,
	input  logic [3:0]         res_month,
	input  logic [4:0]         res_day,
	input  logic signed [22:0] day_difference,
	input  logic               base_replaced,
	input  logic               out_of_range,
	output int                 pending,
	output int                 errors
);

	gdo_tb_pkg::date_result_t expected_q[$];

	function automatic bit leap_year(input int y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int days_in(input int y, input int m);
		int len;
		case (m)
			2: len = leap_year(y) ? 29 : 28;
			4, 6, 9, 11: len = 30;
			1, 3, 5, 7, 8, 10, 12: len = 31;
			default: len = 0;
		endcase
		return len;
	endfunction

	function automatic bit date_ok(input int y, input int m, input int d);
		if (y < 1 || y > YEAR_MAX || m < 1 || m > 12)
			return 1'b0;
		return d >= 1 && d <= days_in(y, m);
	endfunction

	// days since 0001-01-01
	function automatic longint day_index(input int y, input int m, input int d);
		longint p;
		longint n;
		p = longint'(y) - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400;
		for (int k = 1; k < m; k++)
			n += longint'(days_in(y, k));
		return n + longint'(d) - 1;
	endfunction

	function automatic void date_of_index(input longint n, output int y, output int m,
			output int d);
		longint q400, q100, q4, q1, r;
		q400 = n / 146097;
		r = n % 146097;
		q100 = r / 36524;
		if (q100 > 3)
			q100 = 3;
		r -= q100 * 36524;
		q4 = r / 1461;
		r -= q4 * 1461;
		q1 = r / 365;
		if (q1 > 3)
			q1 = 3;
		r -= q1 * 365;
		y = int'(400 * q400 + 100 * q100 + 4 * q4 + q1 + 1);
		m = 1;
		while (m < 12 && r >= longint'(days_in(y, m))) begin
			r -= longint'(days_in(y, m));
			m++;
		end
		d = int'(r) + 1;
	endfunction

	function automatic gdo_tb_pkg::date_result_t predict_result(
			input gdo_tb_pkg::date_op_e op, input int by, input int bm, input int bd,
			input int oy, input int om, input int od, input longint off);
		gdo_tb_pkg::date_result_t r;
		longint nb, n, last_day;
		int y, m, d;
		r = '{year: '0, month: '0, day: '0, diff: '0, replaced: 1'b0, oor: 1'b0};
		if (!date_ok(by, bm, bd)) begin
			by = gdo_pkg::DEF_YEAR;
			bm = 1;
			bd = 1;
			r.replaced = 1'b1;
		end
		nb = day_index(by, bm, bd);
		if (op == gdo_tb_pkg::MODE_SHIFT) begin
			n = nb + off;
			last_day = day_index(YEAR_MAX, 12, 31);
			if (n < 0) begin
				n = 0;
				r.oor = 1'b1;
			end else if (n > last_day) begin
				n = last_day;
				r.oor = 1'b1;
			end
			date_of_index(n, y, m, d);
			r.year = 14'(y);
			r.month = 4'(m);
			r.day = 5'(d);
		end else begin
			if (!date_ok(oy, om, od)) begin
				oy = gdo_pkg::DEF_YEAR;
				om = 1;
				od = 1;
			end
			n = nb - day_index(oy, om, od);
			if (n > gdo_pkg::DIFF_MAX)
				n = gdo_pkg::DIFF_MAX;
			if (n < gdo_pkg::DIFF_MIN)
				n = gdo_pkg::DIFF_MIN;
			r.diff = 23'(n);
		end
		return r;
	endfunction

	function automatic bit field_differs(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gdo_tb_pkg::date_result_t want;
		bit bad;
		if (!arst_n) begin
			expected_q.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			// retire the oldest expectation before queueing a new one
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result expected none, got %0d-%0d-%0d diff %0d", $time,
						res_year, res_month, res_day, day_difference);
					errors <= errors + 1;
				end else begin
					want = expected_q.pop_front();
					bad = 1'b0;
					bad |= field_differs("res_year", want.year, res_year);
					bad |= field_differs("res_month", want.month, res_month);
					bad |= field_differs("res_day", want.day, res_day);
					bad |= field_differs("day_difference", want.diff, day_difference);
					bad |= field_differs("base_replaced", want.replaced, base_replaced);
					bad |= field_differs("out_of_range", want.oor, out_of_range);
					if (bad)
						errors <= errors + 1;
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_result(gdo_tb_pkg::date_op_e'(mode),
					int'(base_year), int'(base_month), int'(base_day), int'(other_year),
					int'(other_month), int'(other_day), longint'(offset)));
			pending <= expected_q.size();
		end
	end

endmodule

/* bench/tb.sv */
// Testbench top for gregorian_date_offset: clock, reset, directed and random
// commands with sender gaps, watchdog and verdict. Depends on gdo_tb_pkg and gdo_checker.
`timescale 1ns / 1ps

module tb;

	localparam int YEAR_MAX = 9999;
	localparam int QUIET_LIMIT = 2000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               mode;
	logic [13:0]        base_year;
	logic [3:0]         base_month;
	logic [4:0]         base_day;
	logic [13:0]        other_year;
	logic [3:0]         other_month;
	logic [4:0]         other_day;
	logic signed [22:0] offset;
	logic               done;
	logic [13:0]        res_year;
	logic [3:0]         res_month;
	logic [4:0]         res_day;
	logic signed [22:0] day_difference;
	logic               base_replaced;
	logic               out_of_range;

	int pending;
	int errors;
	int idle_pct;
	int quiet;

	gregorian_date_offset #(.YEAR_MAX(YEAR_MAX)) DUT (.*);

	gdo_checker #(.YEAR_MAX(YEAR_MAX)) u_checker (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// end the run if no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_cmd(input gdo_tb_pkg::date_op_e op, input logic [13:0] by,
			input logic [3:0] bm, input logic [4:0] bd, input logic [13:0] oy,
			input logic [3:0] om, input logic [4:0] od, input logic signed [22:0] off);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(1, 50)) @(posedge clk);
			else
				@(posedge clk);
		end
		mode <= op;
		base_year <= by;
		base_month <= bm;
		base_day <= bd;
		other_year <= oy;
		other_month <= om;
		other_day <= od;
		offset <= off;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [13:0] pick_year();
		case ($urandom_range(7))
			0: return 14'($urandom_range(1, 4));
			1: return 14'($urandom_range(YEAR_MAX - 4, YEAR_MAX));
			2: return 14'(1600 + 100 * $urandom_range(4));
			default: return 14'($urandom_range(1, YEAR_MAX));
		endcase
	endfunction

	task automatic random_cmd();
		logic [13:0] by, oy;
		logic [3:0] bm, om;
		logic [4:0] bd, od;
		logic signed [22:0] off;
		if ($urandom_range(99) < 12) begin
			by = 14'($urandom);
			bm = 4'($urandom);
			bd = 5'($urandom);
		end else begin
			by = pick_year();
			bm = 4'($urandom_range(1, 12));
			bd = ($urandom_range(3) == 0) ? 5'($urandom_range(28, 31)) : 5'($urandom_range(1, 28));
		end
		oy = pick_year();
		om = 4'($urandom_range(1, 12));
		od = ($urandom_range(3) == 0) ? 5'($urandom_range(28, 31)) : 5'($urandom_range(1, 28));
		case ($urandom_range(3))
			0: off = 23'($urandom_range(800) - 400);
			1: off = 23'($urandom_range(200000) - 100000);
			2: off = 23'($urandom_range(4000000) - 2000000);
			default: off = 23'($urandom);
		endcase
		send_cmd(gdo_tb_pkg::date_op_e'($urandom_range(1)), by, bm, bd, oy, om, od, off);
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		mode <= gdo_tb_pkg::MODE_SHIFT;
		base_year <= '0;
		base_month <= '0;
		base_day <= '0;
		other_year <= '0;
		other_month <= '0;
		other_day <= '0;
		offset <= '0;
		idle_pct = 21;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calendar edges and saturation
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2000, 4'd1, 5'd1, 14'd1, 4'd1, 5'd1, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd1, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd1, -23'sd1);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1, 23'sd1);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2000, 4'd2, 5'd28, 14'd1, 4'd1, 5'd1, 23'sd1);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd1900, 4'd2, 5'd28, 14'd1, 4'd1, 5'd1, 23'sd1);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2024, 4'd2, 5'd29, 14'd1, 4'd1, 5'd1, 23'sd366);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2023, 4'd8, 5'd30, 14'd1, 4'd1, 5'd1, 23'sd1);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2023, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1, 23'sd1);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd5000, 4'd6, 5'd15, 14'd1, 4'd1, 5'd1,
			23'sh3FFFFF);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd5000, 4'd6, 5'd15, 14'd1, 4'd1, 5'd1,
			23'sh400000);
		// invalid base dates
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd0, 4'd1, 5'd1, 14'd1, 4'd1, 5'd1, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd16383, 4'd15, 5'd31, 14'd1, 4'd1, 5'd1,
			23'sd10);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2001, 4'd13, 5'd1, 14'd1, 4'd1, 5'd1, -23'sd5);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2001, 4'd0, 5'd1, 14'd1, 4'd1, 5'd1, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2001, 4'd3, 5'd0, 14'd1, 4'd1, 5'd1, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2001, 4'd4, 5'd31, 14'd1, 4'd1, 5'd1, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_SHIFT, 14'd2023, 4'd2, 5'd29, 14'd1, 4'd1, 5'd1, 23'sd0);
		// differences, including an invalid second date
		send_cmd(gdo_tb_pkg::MODE_DIFF, 14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_DIFF, 14'd1, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_DIFF, 14'd2024, 4'd3, 5'd1, 14'd2024, 4'd3, 5'd1,
			23'sh3FFFFF);
		send_cmd(gdo_tb_pkg::MODE_DIFF, 14'd2024, 4'd3, 5'd1, 14'd2023, 4'd2, 5'd31, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_DIFF, 14'd0, 4'd0, 5'd0, 14'd2000, 4'd2, 5'd29, 23'sd0);
		send_cmd(gdo_tb_pkg::MODE_DIFF, 14'd1600, 4'd2, 5'd29, 14'd1900, 4'd2, 5'd29,
			23'sd0);

		repeat (330) random_cmd();
		idle_pct = 54;
		repeat (330) random_cmd();
		idle_pct = 0;
		repeat (340) random_cmd();

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
